### hw/rtl/olist_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered list package
// Shared widths, operation and status codes, and the command that every
// cell of the list chain sees.
// ----------------------------------------------------------------------------
package olist_pkg;

	localparam int DATA_W        = 32;
	localparam int OP_W          = 2;
	localparam int STATUS_W      = 2;
	localparam int ENTRY_COUNT_W = 5;

	localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

	typedef struct packed {
		logic              go;
		logic              append;
		logic              delete_hit;
		logic [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage
`default_nettype wire

### hw/rtl/olist_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered list channels
// Request channel (operation, value) and response channel (status, count).
// ----------------------------------------------------------------------------
interface olist_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [31:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

interface olist_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [4:0] entry_count;

	modport source (output valid, output status, output entry_count, input ready);
	modport sink (input valid, input status, input entry_count, output ready);
endinterface
`default_nettype wire

### hw/rtl/olist_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one entry, compares it with the request value, passes the match
// chain on, and takes the value on append or the neighbor's entry on delete.
// ----------------------------------------------------------------------------
module olist_cell (
	input  wire logic                        clk,
	input  wire olist_pkg::cell_cmd_t        cmd,
	input  wire logic                        here_valid,
	input  wire logic                        here_tail,
	input  wire logic [olist_pkg::DATA_W-1:0] next_entry,
	input  wire logic                        hit_in,
	output logic [olist_pkg::DATA_W-1:0]     entry,
	output logic                             hit_out
);
	import olist_pkg::*;

	logic [DATA_W-1:0] entry_q;

	assign entry   = entry_q;
	assign hit_out = hit_in | (here_valid & (entry_q == cmd.value));

	always_ff @(posedge clk) begin
		if (cmd.go && cmd.append && here_tail) begin
			entry_q <= cmd.value;
		end else if (cmd.go && cmd.delete_hit && hit_out) begin
			entry_q <= next_entry;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/ordered_list_append_delete_find.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered list with append, delete first match and find
// Chain of DEPTH cells; a match chain runs through the cells and every
// cell at or after the first match shifts in its neighbor on delete.
// The response is registered in the cycle after the request is accepted.
// Throughput: one request per cycle while responses are taken.
// The match chain through all DEPTH cells sets the cycle time.
// Reset clears the entry count and the response valid; entries are not cleared.
// ----------------------------------------------------------------------------
module ordered_list_append_delete_find #(
	parameter int DEPTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	olist_req_if.sink   req,
	olist_rsp_if.source rsp
);
	import olist_pkg::*;

	localparam int COUNT_W = $clog2(DEPTH + 1);

	logic [COUNT_W-1:0]       count_q;
	logic [COUNT_W-1:0]       count_nx;
	logic                     rsp_valid_q;
	logic [STATUS_W-1:0]      status_q;
	logic [ENTRY_COUNT_W-1:0] entry_count_q;
	logic [STATUS_W-1:0]      status_nx;
	logic                     accept;
	logic                     full;
	logic                     found;
	logic                     is_append;
	logic                     is_delete;
	cell_cmd_t                cmd;
	logic [DATA_W-1:0]        entry_c [DEPTH];
	logic [DEPTH:0]           hit_c;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_append = (req.operation == OP_APPEND);
	assign is_delete = (req.operation == OP_DELETE);
	assign full      = (count_q == COUNT_W'(DEPTH));
	assign hit_c[0]  = 1'b0;
	assign found     = hit_c[DEPTH];

	assign cmd.go         = accept;
	assign cmd.append     = is_append && !full;
	assign cmd.delete_hit = is_delete && found;
	assign cmd.value      = req.value;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] next_entry;
		if (i == DEPTH - 1) begin : g_last
			assign next_entry = entry_c[i];
		end else begin : g_mid
			assign next_entry = entry_c[i+1];
		end
		olist_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.here_valid (count_q > COUNT_W'(i)),
			.here_tail  (count_q == COUNT_W'(i)),
			.next_entry (next_entry),
			.hit_in     (hit_c[i]),
			.entry      (entry_c[i]),
			.hit_out    (hit_c[i+1])
		);
	end

	always_comb begin
		count_nx  = count_q;
		status_nx = ST_OK;
		if (is_append) begin
			if (full) begin
				status_nx = ST_FULL;
			end else begin
				count_nx = count_q + COUNT_W'(1);
			end
		end else if (is_delete) begin
			if (found) begin
				count_nx = count_q - COUNT_W'(1);
			end else begin
				status_nx = ST_ABSENT;
			end
		end else if (!found) begin
			status_nx = ST_ABSENT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nx;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_nx;
			entry_count_q <= ENTRY_COUNT_W'(count_nx);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = entry_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(DEPTH))
		else $error("entry count above depth");

	a_accept_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("accepted request without response");

	a_append_grow: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_append && !full |=> count_q == $past(count_q) + COUNT_W'(1))
		else $error("append did not grow list");

	a_delete_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_delete && found |=> count_q == $past(count_q) - COUNT_W'(1))
		else $error("delete did not shrink list");

	a_hold_count: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("count changed without request");

endmodule
`default_nettype wire
